[sv/gtnl_pkg.sv]
// Shared types, widths, register codes and helpers for the grid triangle
// neighbour lookup unit. No dependencies.
package gtnl_pkg;

   // Field widths
   localparam int CFG_W   = 13;           // columns / rows register width
   localparam int NUM_W   = 25;           // triangle number width
   localparam int HALF_W  = NUM_W - 1;    // triangle pair (cell) number width
   localparam int VTX_W   = 24;           // vertex point index width
   localparam int NB_W    = 26;           // signed neighbour number width
   localparam int ADDR_W  = 4;            // register byte address width
   localparam int DATA_W  = 32;           // register data width
   localparam int CFG_MAX = (1 << CFG_W) - 1;

   // Parameter defaults
   localparam int DEF_MAX_COLUMNS = 4096;
   localparam int DEF_MAX_ROWS    = 4096;

   // Register indexes (word address)
   localparam logic [1:0] REG_COLUMNS = 2'd0;
   localparam logic [1:0] REG_ROWS    = 2'd1;
   localparam logic [1:0] REG_WRAP    = 2'd2;

   // Per-item grid info that travels down the pipeline with the item
   typedef struct packed {
      logic [NUM_W-1:0] n;       // triangle number
      logic [CFG_W-1:0] ni;      // clamped points per row
      logic [CFG_W-1:0] nj;      // clamped rows of points
      logic             wrap;    // periodic longitude
      logic [CFG_W-1:0] m;       // cells per row
      logic             num_ok;  // number lies inside the grid
   } side_type;

   // Saturate a grid size to 2..hi
   function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
      logic [CFG_W-1:0] res;
      if (v < CFG_W'(2)) begin
         res = CFG_W'(2);
      end else if (32'(v) > hi) begin
         res = CFG_W'(hi);
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

[sv/gtnl_divider.sv]
// Pipelined restoring divider for the grid lookup: one quotient bit per stage.
// Splits a cell number into cell row (quotient) and cell column (remainder).
// Depends on gtnl_pkg.
module gtnl_divider #(
   parameter int QW = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [gtnl_pkg::HALF_W-1:0] in_dividend,
   input  gtnl_pkg::side_type       in_side,
   output logic                     out_valid,
   output logic [QW-1:0]            out_quotient,
   output logic [gtnl_pkg::HALF_W-1:0] out_remainder,
   output gtnl_pkg::side_type       out_side
);
   import gtnl_pkg::*;

   localparam int SW = ((HALF_W > CFG_W + QW) ? HALF_W : CFG_W + QW) + 1;

   logic              valid_ff [QW];
   logic [HALF_W-1:0] rem_ff   [QW];
   logic [QW-1:0]     quo_ff   [QW];
   side_type          side_ff  [QW];

   logic              valid_src [QW];
   logic [HALF_W-1:0] rem_src   [QW];
   logic [QW-1:0]     quo_src   [QW];
   side_type          side_src  [QW];
   logic [SW-1:0]     trial     [QW];
   logic              fits      [QW];

   // Select each stage's source and try subtracting the shifted divisor
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            valid_src[k] = in_valid;
            rem_src[k]   = in_dividend;
            quo_src[k]   = '0;
            side_src[k]  = in_side;
         end else begin
            valid_src[k] = valid_ff[k-1];
            rem_src[k]   = rem_ff[k-1];
            quo_src[k]   = quo_ff[k-1];
            side_src[k]  = side_ff[k-1];
         end
         trial[k] = SW'(rem_src[k]) - (SW'(side_src[k].m) << (QW - 1 - k));
         fits[k]  = !trial[k][SW-1];
      end
   end

   // Advance one quotient bit per stage
   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_src[k];
         end
         rem_ff[k]  <= fits[k] ? trial[k][HALF_W-1:0] : rem_src[k];
         quo_ff[k]  <= quo_src[k] | (QW'(fits[k]) << (QW - 1 - k));
         side_ff[k] <= side_src[k];
      end
   end

   assign out_valid     = valid_ff[QW-1];
   assign out_quotient  = quo_ff[QW-1];
   assign out_remainder = rem_ff[QW-1];
   assign out_side      = side_ff[QW-1];

endmodule

[sv/grid_triangle_neighbour_lookup_unit.sv]
// Top level of the grid triangle neighbour lookup unit: register port,
// input capture, divider pipeline, vertex/neighbour assembly.
// Depends on gtnl_pkg and gtnl_divider.

// The unit takes one triangle number per clock cycle and never stalls: busy
// is always low. Each item produces exactly one result, shown for a single
// cycle with rsp_strobe, after input capture, the cell-count stage, the
// restoring divider that splits the cell number into row and column (one
// quotient bit per stage, QW = bits of the cell row, 12 at the default
// MAX_ROWS of 4096), the edge-flag stage and the result register. Results
// are not held: the receiver must take each one in the cycle it appears.
// Write columns, rows and wraps_around only while no item is in flight.
module grid_triangle_neighbour_lookup_unit #(
   parameter int MAX_COLUMNS = gtnl_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gtnl_pkg::DEF_MAX_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [gtnl_pkg::NUM_W-1:0]        req_triangle_number,
   // result channel
   output logic                              rsp_strobe,
   output logic [gtnl_pkg::VTX_W-1:0]        rsp_vertex_first,
   output logic [gtnl_pkg::VTX_W-1:0]        rsp_vertex_second,
   output logic [gtnl_pkg::VTX_W-1:0]        rsp_vertex_third,
   output logic signed [gtnl_pkg::NB_W-1:0]  rsp_neighbour_first,
   output logic signed [gtnl_pkg::NB_W-1:0]  rsp_neighbour_second,
   output logic signed [gtnl_pkg::NB_W-1:0]  rsp_neighbour_third,
   output logic                              rsp_on_border,
   output logic                              rsp_number_valid,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gtnl_pkg::ADDR_W-1:0]       paddr,
   input  logic [gtnl_pkg::DATA_W-1:0]       pwdata,
   output logic [gtnl_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import gtnl_pkg::*;

   localparam int ROWS_EFF = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
   localparam int QW       = (ROWS_EFF > 2) ? $clog2(ROWS_EFF - 1) : 1;
   localparam logic [NB_W-1:0] NONE = '1;

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0] columns_ff;
   logic [CFG_W-1:0] rows_ff;
   logic             wrap_ff;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= CFG_W'(2);
         rows_ff    <= CFG_W'(2);
         wrap_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_COLUMNS: columns_ff <= pwdata[CFG_W-1:0];
            REG_ROWS:    rows_ff    <= pwdata[CFG_W-1:0];
            REG_WRAP:    wrap_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (paddr[3:2])
         REG_COLUMNS: prdata = DATA_W'(columns_ff);
         REG_ROWS:    prdata = DATA_W'(rows_ff);
         REG_WRAP:    prdata = DATA_W'(wrap_ff);
         default:     prdata = '0;
      endcase
   end

   // ---------------- stage 1: capture item and clamped sizes ----------------
   logic             s1_valid_ff;
   logic [NUM_W-1:0] s1_n_ff;
   logic [CFG_W-1:0] s1_ni_ff;
   logic [CFG_W-1:0] s1_nj_ff;
   logic             s1_wrap_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_n_ff    <= req_triangle_number;
      s1_ni_ff   <= clamp_size(columns_ff, MAX_COLUMNS);
      s1_nj_ff   <= clamp_size(rows_ff, MAX_ROWS);
      s1_wrap_ff <= wrap_ff;
   end

   // ---------------- stage 2: cells per row and triangle count ----------------
   logic [CFG_W-1:0]     s1_m;
   logic [2*CFG_W:0]     s1_total;
   logic                 s2_valid_ff;
   side_type             s2_side_ff;
   logic [2*CFG_W:0]     s2_total_ff;

   assign s1_m     = s1_wrap_ff ? s1_ni_ff : s1_ni_ff - CFG_W'(1);
   assign s1_total = (2*CFG_W+1)'({s1_m, 1'b0}) * (2*CFG_W+1)'(s1_nj_ff - CFG_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_side_ff.n      <= s1_n_ff;
      s2_side_ff.ni     <= s1_ni_ff;
      s2_side_ff.nj     <= s1_nj_ff;
      s2_side_ff.wrap   <= s1_wrap_ff;
      s2_side_ff.m      <= s1_m;
      s2_side_ff.num_ok <= 1'b0;
      s2_total_ff       <= s1_total;
   end

   // ---------------- stages 3..QW+2: cell row and column ----------------
   side_type          div_side_in;
   logic              div_valid;
   logic [QW-1:0]     div_quo;
   logic [HALF_W-1:0] div_rem;
   side_type          div_side;

   // Range check rides along with the first divider step
   always_comb begin
      div_side_in        = s2_side_ff;
      div_side_in.num_ok = (2*CFG_W+1)'(s2_side_ff.n) < s2_total_ff;
   end

   gtnl_divider #(
      .QW (QW)
   ) u_divider (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid_ff),
      .in_dividend   (s2_side_ff.n[NUM_W-1:1]),
      .in_side       (div_side_in),
      .out_valid     (div_valid),
      .out_quotient  (div_quo),
      .out_remainder (div_rem),
      .out_side      (div_side)
   );

   // ---------------- stage QW+3: row base index and edge flags ----------------
   logic [CFG_W-1:0] d_i;
   logic [CFG_W-1:0] d_j;

   logic             s4_valid_ff;
   side_type         s4_side_ff;
   logic [NB_W-1:0]  s4_jn_ff;
   logic [CFG_W-1:0] s4_i_ff;
   logic             s4_first_row_ff;
   logic             s4_last_row_ff;
   logic             s4_left_col_ff;
   logic             s4_last_col_ff;
   logic             s4_pen_col_ff;

   assign d_i = div_rem[CFG_W-1:0];
   assign d_j = CFG_W'(div_quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= div_valid;
      end
      s4_side_ff      <= div_side;
      s4_jn_ff        <= NB_W'(d_j) * NB_W'(div_side.ni);
      s4_i_ff         <= d_i;
      s4_first_row_ff <= (d_j == '0);
      s4_last_row_ff  <= (d_j >= div_side.nj - CFG_W'(2));
      s4_left_col_ff  <= (d_i == '0);
      s4_last_col_ff  <= (d_i == div_side.ni - CFG_W'(1));
      s4_pen_col_ff   <= (d_i >= div_side.ni - CFG_W'(2));
   end

   // ---------------- stage QW+4: vertices, neighbours, border ----------------
   logic            even;
   logic            closing;
   logic [NB_W-1:0] b26;
   logic [NB_W-1:0] t26;
   logic [NB_W-1:0] ni26;
   logic [NB_W-1:0] i26;
   logic [NB_W-1:0] p0;
   logic [NB_W-1:0] p1;
   logic [NB_W-1:0] p2;
   logic [NB_W-1:0] p3;
   logic [NB_W-1:0] v0;
   logic [NB_W-1:0] v1;
   logic [NB_W-1:0] v2;
   logic [NB_W-1:0] nb0;
   logic [NB_W-1:0] nb1;
   logic [NB_W-1:0] nb2;

   always_comb begin
      even    = ~s4_side_ff.n[0];
      closing = s4_side_ff.wrap & s4_last_col_ff;
      b26     = NB_W'({s4_side_ff.n[NUM_W-1:1], 1'b0});
      t26     = NB_W'({s4_side_ff.m, 1'b0});
      ni26    = NB_W'(s4_side_ff.ni);
      i26     = NB_W'(s4_i_ff);

      // Cell corners, the closing cell folds back to column 0
      p0 = s4_jn_ff + i26;
      p1 = closing ? s4_jn_ff : s4_jn_ff + i26 + NB_W'(1);
      p2 = s4_jn_ff + ni26 + i26;
      p3 = closing ? s4_jn_ff + ni26 : s4_jn_ff + ni26 + i26 + NB_W'(1);

      if (even) begin
         v0  = p0;
         v1  = p1;
         v2  = p2;
         nb0 = s4_first_row_ff ? NONE : b26 - t26 + NB_W'(1);
         nb1 = b26 + NB_W'(1);
         if (!s4_left_col_ff) begin
            nb2 = b26 - NB_W'(1);
         end else begin
            nb2 = s4_side_ff.wrap ? b26 + t26 - NB_W'(1) : NONE;
         end
      end else begin
         v0  = p2;
         v1  = p3;
         v2  = p1;
         nb0 = s4_last_row_ff ? NONE : b26 + t26;
         if (s4_side_ff.wrap) begin
            nb1 = s4_last_col_ff ? b26 - t26 + NB_W'(2) : b26 + NB_W'(2);
         end else begin
            nb1 = s4_pen_col_ff ? NONE : b26 + NB_W'(2);
         end
         nb2 = b26;
      end
   end

   logic                   strobe_ff;
   logic [VTX_W-1:0]       vertex_first_ff;
   logic [VTX_W-1:0]       vertex_second_ff;
   logic [VTX_W-1:0]       vertex_third_ff;
   logic [NB_W-1:0]        neighbour_first_ff;
   logic [NB_W-1:0]        neighbour_second_ff;
   logic [NB_W-1:0]        neighbour_third_ff;
   logic                   on_border_ff;
   logic                   number_valid_ff;

   // Register the result, blank it for numbers beyond the grid
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s4_valid_ff;
      end
      if (s4_side_ff.num_ok) begin
         vertex_first_ff     <= v0[VTX_W-1:0];
         vertex_second_ff    <= v1[VTX_W-1:0];
         vertex_third_ff     <= v2[VTX_W-1:0];
         neighbour_first_ff  <= nb0;
         neighbour_second_ff <= nb1;
         neighbour_third_ff  <= nb2;
         on_border_ff        <= (nb0 == NONE) | (nb1 == NONE) | (nb2 == NONE);
      end else begin
         vertex_first_ff     <= '0;
         vertex_second_ff    <= '0;
         vertex_third_ff     <= '0;
         neighbour_first_ff  <= NONE;
         neighbour_second_ff <= NONE;
         neighbour_third_ff  <= NONE;
         on_border_ff        <= 1'b0;
      end
      number_valid_ff <= s4_side_ff.num_ok;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_vertex_first     = vertex_first_ff;
   assign rsp_vertex_second    = vertex_second_ff;
   assign rsp_vertex_third     = vertex_third_ff;
   assign rsp_neighbour_first  = neighbour_first_ff;
   assign rsp_neighbour_second = neighbour_second_ff;
   assign rsp_neighbour_third  = neighbour_third_ff;
   assign rsp_on_border        = on_border_ff;
   assign rsp_number_valid     = number_valid_ff;

endmodule

[bench/tb_grid_triangle_neighbour_lookup_unit.sv]
// Self-checking bench for the grid triangle neighbour lookup unit: directed
// grid corners, then randomized lookups over many grid sizes.
// Depends on gtnl_pkg and the unit's RTL; no other files.
module tb_grid_triangle_neighbour_lookup_unit;
   import gtnl_pkg::*;

   localparam int  MAX_COLUMNS    = DEF_MAX_COLUMNS;
   localparam int  MAX_ROWS       = DEF_MAX_ROWS;
   localparam int  RESULT_LATENCY = 16;
   localparam longint NO_NEIGHBOUR = -1;
   // Register index past the end of the register list
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // Expected outcome of one lookup, tagged with its triangle number
   typedef struct packed {
      logic [NUM_W-1:0]       number;
      logic [VTX_W-1:0]       vertex_first;
      logic [VTX_W-1:0]       vertex_second;
      logic [VTX_W-1:0]       vertex_third;
      logic signed [NB_W-1:0] neighbour_first;
      logic signed [NB_W-1:0] neighbour_second;
      logic signed [NB_W-1:0] neighbour_third;
      logic                   on_border;
      logic                   number_valid;
   } lookup_result_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [NUM_W-1:0]       req_triangle_number;
   logic                   rsp_strobe;
   logic [VTX_W-1:0]       rsp_vertex_first;
   logic [VTX_W-1:0]       rsp_vertex_second;
   logic [VTX_W-1:0]       rsp_vertex_third;
   logic signed [NB_W-1:0] rsp_neighbour_first;
   logic signed [NB_W-1:0] rsp_neighbour_second;
   logic signed [NB_W-1:0] rsp_neighbour_third;
   logic                   rsp_on_border;
   logic                   rsp_number_valid;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [ADDR_W-1:0]      paddr;
   logic [DATA_W-1:0]      pwdata;
   logic [DATA_W-1:0]      prdata;
   logic                   pready;

   // Bench copy of the grid registers
   logic [CFG_W-1:0]       grid_columns;
   logic [CFG_W-1:0]       grid_rows;
   logic                   grid_wrap;

   lookup_result_type      pending_lookups[$];
   int                     error_count;

   grid_triangle_neighbour_lookup_unit uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_triangle_number  (req_triangle_number),
      .rsp_strobe           (rsp_strobe),
      .rsp_vertex_first     (rsp_vertex_first),
      .rsp_vertex_second    (rsp_vertex_second),
      .rsp_vertex_third     (rsp_vertex_third),
      .rsp_neighbour_first  (rsp_neighbour_first),
      .rsp_neighbour_second (rsp_neighbour_second),
      .rsp_neighbour_third  (rsp_neighbour_third),
      .rsp_on_border        (rsp_on_border),
      .rsp_number_valid     (rsp_number_valid),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always #2 clock = ~clock;

   // Saturate a grid size register to its usable range
   function automatic longint grid_points(input logic [CFG_W-1:0] v, input int hi);
      longint res;
      res = longint'(v);
      if (res < 2) res = 2;
      if (res > hi) res = hi;
      return res;
   endfunction

   function automatic longint triangles_per_row();
      longint ni;
      ni = grid_points(grid_columns, MAX_COLUMNS);
      return grid_wrap ? 2 * ni : 2 * (ni - 1);
   endfunction

   function automatic longint triangle_count();
      return triangles_per_row() * (grid_points(grid_rows, MAX_ROWS) - 1);
   endfunction

   // Compute vertices, neighbours and flags of one triangle
   function automatic lookup_result_type predict_lookup(input logic [NUM_W-1:0] n);
      lookup_result_type r;
      longint ni, nj, per_row, pair, ci, cj;
      longint p0, p1, p2, p3, nb0, nb1, nb2;
      bit closing;
      ni      = grid_points(grid_columns, MAX_COLUMNS);
      nj      = grid_points(grid_rows, MAX_ROWS);
      per_row = triangles_per_row();
      r        = '0;
      r.number = n;
      if (longint'(n) >= per_row * (nj - 1)) begin
         r.neighbour_first  = NB_W'(NO_NEIGHBOUR);
         r.neighbour_second = NB_W'(NO_NEIGHBOUR);
         r.neighbour_third  = NB_W'(NO_NEIGHBOUR);
         return r;
      end
      pair    = longint'(n) & ~longint'(1);
      ci      = (pair % per_row) / 2;
      cj      = pair / per_row;
      closing = grid_wrap && (ci == ni - 1);
      p0 = cj * ni + ci;
      p1 = closing ? cj * ni : cj * ni + ci + 1;
      p2 = (cj + 1) * ni + ci;
      p3 = closing ? (cj + 1) * ni : (cj + 1) * ni + ci + 1;
      if (!n[0]) begin
         r.vertex_first  = VTX_W'(p0);
         r.vertex_second = VTX_W'(p1);
         r.vertex_third  = VTX_W'(p2);
         nb0 = (cj > 0) ? pair - per_row + 1 : NO_NEIGHBOUR;
         nb1 = pair + 1;
         if (ci > 0) nb2 = pair - 1;
         else nb2 = grid_wrap ? pair + per_row - 1 : NO_NEIGHBOUR;
      end else begin
         r.vertex_first  = VTX_W'(p2);
         r.vertex_second = VTX_W'(p3);
         r.vertex_third  = VTX_W'(p1);
         nb0 = (cj < nj - 2) ? pair + per_row : NO_NEIGHBOUR;
         if (grid_wrap) nb1 = (ci < ni - 1) ? pair + 2 : pair - per_row + 2;
         else nb1 = (ci < ni - 2) ? pair + 2 : NO_NEIGHBOUR;
         nb2 = pair;
      end
      r.neighbour_first  = NB_W'(nb0);
      r.neighbour_second = NB_W'(nb1);
      r.neighbour_third  = NB_W'(nb2);
      r.on_border    = (nb0 == NO_NEIGHBOUR) || (nb1 == NO_NEIGHBOUR) ||
                       (nb2 == NO_NEIGHBOUR);
      r.number_valid = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [NUM_W-1:0] n,
                              input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("triangle %0d %s: got %0h expected %0h",
                                   n, name, got, want));
   endtask

   // Compare each result against the oldest pending lookup
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("result with no lookup pending");
         end else begin
            want = pending_lookups.pop_front();
            check_field("vertex_first", want.number, 32'(rsp_vertex_first),
                        32'(want.vertex_first));
            check_field("vertex_second", want.number, 32'(rsp_vertex_second),
                        32'(want.vertex_second));
            check_field("vertex_third", want.number, 32'(rsp_vertex_third),
                        32'(want.vertex_third));
            check_field("neighbour_first", want.number, 32'(rsp_neighbour_first),
                        32'(want.neighbour_first));
            check_field("neighbour_second", want.number, 32'(rsp_neighbour_second),
                        32'(want.neighbour_second));
            check_field("neighbour_third", want.number, 32'(rsp_neighbour_third),
                        32'(want.neighbour_third));
            check_field("on_border", want.number, 32'(rsp_on_border),
                        32'(want.on_border));
            check_field("number_valid", want.number, 32'(rsp_number_valid),
                        32'(want.number_valid));
         end
      end
   end

   // Present one item and hold it until accepted; start stays high
   task automatic issue_lookup(input logic [NUM_W-1:0] n);
      start               <= 1'b1;
      req_triangle_number <= n;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_lookups.insert(pending_lookups.size(), predict_lookup(n));
   endtask

   // Insert a random gap, mostly short, now and then long
   task automatic pause_sender(input bit bursty);
      int r, gap;
      r = $urandom_range(0, 99);
      if (bursty || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and hold until every pending lookup has come back
   task automatic wait_for_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 4) @(posedge clock);
   endtask

   // Setup and access phase of one register write, then idle with psel low
   task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_COLUMNS: grid_columns = data[CFG_W-1:0];
         REG_ROWS:    grid_rows    = data[CFG_W-1:0];
         REG_WRAP:    grid_wrap    = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reprogram the grid once idle; junk upper bits must be ignored
   task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rws,
                           input logic wrap);
      wait_for_idle();
      write_register(REG_COLUMNS, ($urandom & ~32'(CFG_MAX)) | 32'(cols));
      write_register(REG_ROWS, ($urandom & ~32'(CFG_MAX)) | 32'(rws));
      write_register(REG_WRAP, ($urandom & ~32'd1) | 32'(wrap));
   endtask

   task automatic issue_list(input logic [NUM_W-1:0] list[$]);
      foreach (list[k]) begin
         issue_lookup(list[k]);
         pause_sender(1'b0);
      end
   endtask

   // Reset values give a 2x2 open grid of two triangles
   task automatic test_reset_grid();
      issue_list('{0, 1, 2, {NUM_W{1'b1}}});
   endtask

   // Open grid: left, right, top and bottom borders, one past the end
   task automatic test_open_grid();
      set_grid(4, 3, 1'b0);
      issue_list('{0, 1, 4, 5, 6, 11, 12});
   endtask

   // Periodic grid: closing cell and wrapped left/right neighbours
   task automatic test_wrapped_grid();
      set_grid(4, 3, 1'b1);
      issue_list('{0, 1, 6, 7, 9, 15, 16});
   endtask

   // Sizes below and above range saturate; unknown register is ignored
   task automatic test_size_saturation();
      set_grid(0, 1, 1'b0);
      issue_list('{1, 2});
      set_grid(CFG_MAX, 4097, 1'b1);
      write_register(REG_UNUSED, $urandom);
      issue_list('{0, 8191, NUM_W'(triangle_count() - 1), NUM_W'(triangle_count()),
                   {NUM_W{1'b1}}});
   endtask

   // Pick a triangle: mostly inside, some on borders, some past the end
   function automatic logic [NUM_W-1:0] pick_triangle();
      longint per_row, total, cells, nj, cj, ci;
      int r;
      per_row = triangles_per_row();
      total   = triangle_count();
      cells   = per_row / 2;
      nj      = grid_points(grid_rows, MAX_ROWS);
      r       = $urandom_range(0, 99);
      if (r < 65) return NUM_W'($urandom_range(0, 32'(total - 1)));
      if (r < 88) begin
         case ($urandom_range(0, 2))
            0:       cj = 0;
            1:       cj = nj - 2;
            default: cj = $urandom_range(0, 32'(nj - 2));
         endcase
         case ($urandom_range(0, 2))
            0:       ci = 0;
            1:       ci = cells - 1;
            default: ci = $urandom_range(0, 32'(cells - 1));
         endcase
         return NUM_W'(cj * per_row + 2 * ci + $urandom_range(0, 1));
      end
      if (r < 94) return NUM_W'(total + $urandom_range(0, 3));
      return NUM_W'($urandom);
   endfunction

   // Random lookups over extreme and random grid settings
   task automatic test_random_lookups();
      logic [CFG_W-1:0] cols, rws;
      logic wrap;
      bit bursty;
      for (int phase = 0; phase < 13; phase++) begin
         wrap = 1'($urandom_range(0, 1));
         case (phase)
            0:  begin cols = 2;       rws = 2;       wrap = 1'b0; end
            1:  begin cols = 2;       rws = 2;       wrap = 1'b1; end
            2:  begin cols = 4096;    rws = 4096;    wrap = 1'b0; end
            3:  begin cols = 4096;    rws = 4096;    wrap = 1'b1; end
            4:  begin cols = 2;       rws = 4096;                 end
            5:  begin cols = 4096;    rws = 2;                    end
            6:  begin cols = 1;       rws = 0;                    end
            7:  begin cols = CFG_MAX; rws = 5000;                 end
            8:  begin
               cols = CFG_W'($urandom_range(2, 4096));
               rws  = CFG_W'($urandom_range(2, 4096));
            end
            default: begin
               cols = CFG_W'($urandom_range(2, 40));
               rws  = CFG_W'($urandom_range(2, 20));
            end
         endcase
         set_grid(cols, rws, wrap);
         bursty = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < 50; k++) begin
            // once per few phases, stop feeding until the pipe drains
            if (k == 25 && phase % 4 == 1) wait_for_idle();
            issue_lookup(pick_triangle());
            pause_sender(bursty);
         end
      end
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      start               = 1'b0;
      req_triangle_number = '0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      grid_columns        = 2;
      grid_rows           = 2;
      grid_wrap           = 1'b0;
      error_count         = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_grid();
      test_open_grid();
      test_wrapped_grid();
      test_size_saturation();
      test_random_lookups();

      wait_for_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Bail out if the run hangs
   initial begin
      #1600000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
